>>> design/ftsr_pkg.sv
package ftsr_pkg;

    localparam int FRACTION_BITS_DEF   = 16;
    localparam int MAX_CANVAS_SIDE_DEF = 1024;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_TOP    = 2'd1;
    localparam logic [1:0] PH_BOTTOM = 2'd2;

    localparam logic ADDR_CANVAS_WIDTH = 1'b0;
    localparam logic ADDR_FILL_COLOR   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [25:0] vertex_a_x;
        logic [25:0] vertex_a_y;
        logic [25:0] vertex_b_x;
        logic [25:0] vertex_b_y;
        logic [25:0] vertex_c_x;
        logic [25:0] vertex_c_y;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  span_row;
        logic [9:0]  span_x_first;
        logic [10:0] span_length;
        logic [19:0] span_address;
        logic [7:0]  span_color;
        logic        last_span;
    } out_item_t;

    // Sorted triangle handed from the front end to the back end.
    typedef struct packed {
        logic        cmd;
        logic [25:0] x1;
        logic [25:0] y1;
        logic [25:0] x2;
        logic [25:0] y2;
        logic [25:0] x3;
        logic [25:0] y3;
    } tri_item_t;

endpackage

>>> design/flat_triangle_span_rasterizer.sv
// Channel  | Handshake                  | Payload
// in       | in_valid / in_stall        | in_data  (cmd, three vertices)
// out      | out_valid / out_stall      | out_data (one span)
// config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
// A step item yields its span in the cycle after it leaves the queue: one span per cycle
// while out_stall is low. After a load the next item leaves the queue only when set-up
// is done: three slope divisions, one after another, on the shared bit-serial divider.
// A two-entry queue lets loads and steps be taken in while set-up runs.
// Reset clears all edge state; the block then waits for a load.
module flat_triangle_span_rasterizer #(
    parameter int FRACTION_BITS   = ftsr_pkg::FRACTION_BITS_DEF,
    parameter int MAX_CANVAS_SIDE = ftsr_pkg::MAX_CANVAS_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ftsr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ftsr_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ftsr_pkg::*;

    logic        q_valid, q_stall;
    tri_item_t   q_data;
    logic [10:0] canvas_width_reg;
    logic [7:0]  fill_color_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg <= 11'd320;
            fill_color_reg   <= 8'd0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == ADDR_CANVAS_WIDTH)
                canvas_width_reg <= pwdata[10:0];
            else
                fill_color_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == ADDR_FILL_COLOR)
                prdata = {24'd0, fill_color_reg};
            else
                prdata = {21'd0, canvas_width_reg};
        end
    end

    ftsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_stall  (q_stall),
        .q_data   (q_data)
    );

    ftsr_back #(
        .FRACTION_BITS   (FRACTION_BITS),
        .MAX_CANVAS_SIDE (MAX_CANVAS_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_stall      (q_stall),
        .q_data       (q_data),
        .canvas_width (canvas_width_reg),
        .fill_color   (fill_color_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

>>> design/ftsr_front.sv
module ftsr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ftsr_pkg::in_item_t in_data,
    output logic               q_valid,
    input  logic               q_stall,
    output ftsr_pkg::tri_item_t q_data
);
    import ftsr_pkg::*;

    localparam int DEPTH = 2;

    tri_item_t  mem_reg [DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    tri_item_t  sorted;
    logic       push, pop;
    logic [25:0] ax, ay, bx, by, cx, cy;
    logic        ab, bc, ac;

    // Stable three-element sort by y, as a fixed compare network.
    always_comb
    begin
        ax = in_data.vertex_a_x; ay = in_data.vertex_a_y;
        bx = in_data.vertex_b_x; by = in_data.vertex_b_y;
        cx = in_data.vertex_c_x; cy = in_data.vertex_c_y;
        ab = ay > by;
        bc = by > cy;
        ac = ay > cy;
        sorted.cmd = in_data.cmd;
        if (!ab && !bc)
        begin
            sorted.x1 = ax; sorted.y1 = ay; sorted.x2 = bx; sorted.y2 = by;
            sorted.x3 = cx; sorted.y3 = cy;
        end
        else if (!ab && bc && !ac)
        begin
            sorted.x1 = ax; sorted.y1 = ay; sorted.x2 = cx; sorted.y2 = cy;
            sorted.x3 = bx; sorted.y3 = by;
        end
        else if (!ab && bc)
        begin
            sorted.x1 = cx; sorted.y1 = cy; sorted.x2 = ax; sorted.y2 = ay;
            sorted.x3 = bx; sorted.y3 = by;
        end
        else if (ab && !ac)
        begin
            sorted.x1 = bx; sorted.y1 = by; sorted.x2 = ax; sorted.y2 = ay;
            sorted.x3 = cx; sorted.y3 = cy;
        end
        else if (ab && !bc)
        begin
            sorted.x1 = bx; sorted.y1 = by; sorted.x2 = cx; sorted.y2 = cy;
            sorted.x3 = ax; sorted.y3 = ay;
        end
        else
        begin
            sorted.x1 = cx; sorted.y1 = cy; sorted.x2 = bx; sorted.y2 = by;
            sorted.x3 = ax; sorted.y3 = ay;
        end
    end

    assign in_stall = (cnt_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && !q_stall;
    assign q_data   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= sorted;
    end

endmodule

>>> design/ftsr_divider.sv
module ftsr_divider #(
    parameter int FRACTION_BITS = ftsr_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [25:0] dx_mag,
    input  logic        dx_neg,
    input  logic [25:0] dy,
    output logic        busy,
    output logic [31:0] quotient
);
    import ftsr_pkg::*;

    // Restoring division of |dx| << FRACTION_BITS by dy, one bit a cycle.
    localparam int NB = 26 + FRACTION_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] num_reg, num_next;
    logic [NB-1:0] q_reg, q_next;
    logic [26:0]   rem_reg, rem_next;
    logic [25:0]   den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg;
    logic [26:0]   trial;
    logic          big;

    always_comb
    begin
        trial    = {rem_reg[25:0], num_reg[NB-1]};
        num_next = {num_reg[NB-2:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = trial - {1'b0, den_reg};
            q_next   = {q_reg[NB-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            q_next   = {q_reg[NB-2:0], 1'b0};
        end
        cnt_next = cnt_reg - CW'(1);
    end

    assign busy = busy_reg;

    always_comb
    begin
        if (!neg_reg)
        begin
            big      = |q_reg[NB-1:31];
            quotient = big ? 32'h7FFF_FFFF : {1'b0, q_reg[30:0]};
        end
        else
        begin
            big      = |q_reg[NB-1:32] || (q_reg[31] && |q_reg[30:0]);
            quotient = big ? 32'h8000_0000 : 32'(-q_reg[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_next;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {dx_mag, FRACTION_BITS'(0)};
            den_reg <= dy;
            neg_reg <= dx_neg;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

>>> design/ftsr_back.sv
module ftsr_back #(
    parameter int FRACTION_BITS   = ftsr_pkg::FRACTION_BITS_DEF,
    parameter int MAX_CANVAS_SIDE = ftsr_pkg::MAX_CANVAS_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_stall,
    input  ftsr_pkg::tri_item_t q_data,
    input  logic [10:0]         canvas_width,
    input  logic [7:0]          fill_color,
    output logic                out_valid,
    input  logic                out_stall,
    output ftsr_pkg::out_item_t out_data
);
    import ftsr_pkg::*;

    localparam int RW = $clog2(MAX_CANVAS_SIDE);
    localparam logic [RW:0] RMAX = (RW+1)'(MAX_CANVAS_SIDE - 1);

    localparam logic [2:0] S_RUN  = 3'd0;
    localparam logic [2:0] S_DTOP = 3'd1;
    localparam logic [2:0] S_DBOT = 3'd2;
    localparam logic [2:0] S_DLNG = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]  st_reg;
    tri_item_t   t_reg;
    logic [31:0] long_x_acc_reg, short_x_acc_reg, bottom_start_x_reg;
    logic [31:0] long_slope_reg, top_slope_reg, bottom_slope_reg;
    logic [RW:0] current_row_reg, middle_row_reg, end_row_reg;
    logic        long_on_right_reg;
    logic [1:0]  phase_reg;
    logic [2:0]  which_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [RW:0] r1, r2, r3;
    logic        top_vis, bot_vis, long_vis;
    logic        div_start, div_busy;
    logic [25:0] dxs, dxe, dys, dye, dx_mag;
    logic [31:0] quot;

    function automatic logic [RW:0] round_row(input logic [25:0] v);
        logic [26:0] s;
        logic [26-FRACTION_BITS:0] r;
        s = {1'b0, v} + 27'(1 << (FRACTION_BITS - 1));
        r = s[26:FRACTION_BITS];
        return (r > (27-FRACTION_BITS)'(MAX_CANVAS_SIDE - 1)) ? RMAX : (RW+1)'(r);
    endfunction

    function automatic logic [26-FRACTION_BITS:0] round_coord(input logic [25:0] v);
        logic [26:0] s;
        s = {1'b0, v} + 27'(1 << (FRACTION_BITS - 1));
        return s[26:FRACTION_BITS];
    endfunction

    function automatic logic [RW-1:0] col(input logic [31:0] v);
        logic [31-FRACTION_BITS:0] ip;
        ip = v[31:FRACTION_BITS];
        if (ip[31-FRACTION_BITS])
            return '0;
        if (ip > (32-FRACTION_BITS)'(MAX_CANVAS_SIDE - 1))
            return RW'(MAX_CANVAS_SIDE - 1);
        return ip[RW-1:0];
    endfunction

    assign r1       = round_row(t_reg.y1);
    assign r2       = round_row(t_reg.y2);
    assign r3       = round_row(t_reg.y3);
    assign top_vis  = r2 > r1;
    assign bot_vis  = r3 > r2;
    assign long_vis = r3 > r1;

    always_comb
    begin
        case (which_reg)
            S_DTOP:
            begin
                dxs = t_reg.x1; dxe = t_reg.x2; dys = t_reg.y1; dye = t_reg.y2;
            end
            S_DBOT:
            begin
                dxs = t_reg.x2; dxe = t_reg.x3; dys = t_reg.y2; dye = t_reg.y3;
            end
            default:
            begin
                dxs = t_reg.x1; dxe = t_reg.x3; dys = t_reg.y1; dye = t_reg.y3;
            end
        endcase
        dx_mag = (dxe >= dxs) ? dxe - dxs : dxs - dxe;
    end

    assign div_start = (st_reg == S_DTOP || st_reg == S_DBOT || st_reg == S_DLNG);

    ftsr_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dx_mag   (dx_mag),
        .dx_neg   (dxs > dxe),
        .dy       (dye - dys),
        .busy     (div_busy),
        .quotient (quot)
    );

    // Span of the current row.
    logic [31:0]   left, right;
    logic [RW-1:0] lcol, rcol;
    logic [RW:0]   row_inc;
    logic          step_ok, out_free, last;
    logic [1:0]    phase_nx;
    logic          swap_short;
    logic [31:0]   mul;

    assign left     = long_on_right_reg ? short_x_acc_reg : long_x_acc_reg;
    assign right    = long_on_right_reg ? long_x_acc_reg : short_x_acc_reg;
    assign lcol     = col(left);
    assign rcol     = col(right);
    assign row_inc  = current_row_reg + (RW+1)'(1);
    assign out_free = !out_valid_reg || !out_stall;
    assign mul      = 32'(current_row_reg[RW-1:0]) * 32'(canvas_width);

    always_comb
    begin
        phase_nx   = phase_reg;
        swap_short = 1'b0;
        last       = 1'b0;
        if (phase_reg == PH_TOP)
        begin
            if (row_inc >= middle_row_reg)
            begin
                if (end_row_reg > middle_row_reg)
                begin
                    phase_nx   = PH_BOTTOM;
                    swap_short = 1'b1;
                end
                else
                begin
                    phase_nx = PH_IDLE;
                    last     = 1'b1;
                end
            end
        end
        else if (row_inc >= end_row_reg)
        begin
            phase_nx = PH_IDLE;
            last     = 1'b1;
        end
    end

    assign step_ok = st_reg == S_RUN && q_valid && q_data.cmd == CMD_STEP &&
                     (phase_reg == PH_TOP || phase_reg == PH_BOTTOM) && out_free;
    assign q_stall = !(st_reg == S_RUN &&
                       (q_data.cmd == CMD_LOAD || out_free ||
                        !(phase_reg == PH_TOP || phase_reg == PH_BOTTOM)));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg            <= S_RUN;
            which_reg         <= S_DTOP;
            phase_reg         <= PH_IDLE;
            out_valid_reg     <= 1'b0;
            long_x_acc_reg    <= '0;
            short_x_acc_reg   <= '0;
            long_slope_reg    <= '0;
            top_slope_reg     <= '0;
            bottom_slope_reg  <= '0;
            bottom_start_x_reg <= '0;
            current_row_reg   <= '0;
            middle_row_reg    <= '0;
            end_row_reg       <= '0;
            long_on_right_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (st_reg)
                S_RUN:
                begin
                    if (q_valid && !q_stall && q_data.cmd == CMD_LOAD)
                    begin
                        st_reg    <= S_DTOP;
                        which_reg <= S_DTOP;
                    end
                    else if (step_ok)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.span_row     <= 10'(current_row_reg);
                        out_reg.span_x_first <= 10'(lcol);
                        out_reg.span_length  <= (rcol > lcol) ?
                                                11'(rcol - lcol) + 11'd1 : 11'd1;
                        out_reg.span_address <= 20'(mul + 32'(lcol));
                        out_reg.span_color   <= fill_color;
                        out_reg.last_span    <= last;
                        long_x_acc_reg  <= long_x_acc_reg + long_slope_reg;
                        short_x_acc_reg <= swap_short ? bottom_start_x_reg :
                            short_x_acc_reg + ((phase_reg == PH_TOP) ?
                                               top_slope_reg : bottom_slope_reg);
                        current_row_reg <= row_inc;
                        phase_reg       <= phase_nx;
                    end
                end
                S_DTOP, S_DBOT, S_DLNG:
                    st_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!div_busy)
                    begin
                        case (which_reg)
                            S_DTOP:
                            begin
                                top_slope_reg <= top_vis ? quot : 32'd0;
                                st_reg <= S_DBOT; which_reg <= S_DBOT;
                            end
                            S_DBOT:
                            begin
                                bottom_slope_reg <= bot_vis ? quot : 32'd0;
                                st_reg <= S_DLNG; which_reg <= S_DLNG;
                            end
                            default:
                            begin
                                long_slope_reg <= long_vis ? quot : 32'd0;
                                st_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_FIN:
                begin
                    if (!top_vis)
                        long_on_right_reg <= round_coord(t_reg.x1) > round_coord(t_reg.x2);
                    else if (!bot_vis)
                        long_on_right_reg <= round_coord(t_reg.x3) > round_coord(t_reg.x2);
                    else
                        long_on_right_reg <= $signed(top_slope_reg) < $signed(long_slope_reg);
                    long_x_acc_reg     <= 32'(t_reg.x1);
                    bottom_start_x_reg <= 32'(t_reg.x2);
                    current_row_reg    <= r1;
                    middle_row_reg     <= r2;
                    end_row_reg        <= r3;
                    if (top_vis)
                    begin
                        short_x_acc_reg <= 32'(t_reg.x1);
                        phase_reg       <= PH_TOP;
                    end
                    else if (bot_vis)
                    begin
                        short_x_acc_reg <= 32'(t_reg.x2);
                        phase_reg       <= PH_BOTTOM;
                    end
                    else
                    begin
                        short_x_acc_reg <= 32'(t_reg.x1);
                        phase_reg       <= PH_IDLE;
                    end
                    st_reg <= S_RUN;
                end
                default:
                    st_reg <= S_RUN;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_RUN && q_valid && !q_stall && q_data.cmd == CMD_LOAD)
            t_reg <= q_data;
    end

endmodule

>>> tb/sv/tb_flat_triangle_span_rasterizer.sv
`timescale 1ns / 1ps

module tb_flat_triangle_span_rasterizer;
    import ftsr_pkg::*;

    localparam int FRAC        = FRACTION_BITS_DEF;
    localparam int SIDE        = MAX_CANVAS_SIDE_DEF;
    localparam int SETUP_WAIT  = 600;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1600;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    flat_triangle_span_rasterizer u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scan converter state as the testbench sees it.
    logic [10:0]        width_q = 11'd320;
    logic [7:0]         color_q = 8'd0;
    logic [31:0]        long_x, short_x, mid_start_x;
    logic signed [31:0] long_dx, top_dx, bot_dx;
    logic [10:0]        row_now;
    logic [9:0]         row_mid, row_end;
    logic               long_right;
    logic [1:0]         walk_phase = PH_IDLE;

    out_item_t span_queue[$];
    int        fail_count = 0;
    int        items_sent = 0;
    longint    cycle_count = 0;
    bit        quiet = 1'b0;

    function automatic logic [10:0] round_px(logic [25:0] v);
        logic [31:0] s;
        s = {6'b0, v} + (32'd1 << (FRAC - 1));
        return s[FRAC+10:FRAC];
    endfunction

    function automatic logic [9:0] round_line(logic [25:0] v);
        logic [10:0] r;
        r = round_px(v);
        return (r > SIDE - 1) ? 10'(SIDE - 1) : r[9:0];
    endfunction

    function automatic logic signed [31:0] edge_dxdy(logic [25:0] ys, logic [25:0] ye,
                                                      logic [25:0] xs, logic [25:0] xe);
        longint dy, dx, q;
        dy = longint'(ye) - longint'(ys);
        dx = longint'(xe) - longint'(xs);
        if (dy <= 0)
            return 0;
        q = (dx * (longint'(1) << FRAC)) / dy;
        if (q > 64'sh7FFFFFFF)
            q = 64'sh7FFFFFFF;
        if (q < -64'sh80000000)
            q = -64'sh80000000;
        return q[31:0];
    endfunction

    function automatic longint pixel_col(logic [31:0] acc);
        longint c;
        c = longint'($signed(acc)) >>> FRAC;
        if (c < 0)
            c = 0;
        if (c > SIDE - 1)
            c = SIDE - 1;
        return c;
    endfunction

    task automatic setup_triangle(in_item_t it);
        logic [25:0] vx[3], vy[3];
        logic [25:0] t;
        logic [9:0]  r1, r2, r3;
        logic        top_vis, bot_vis, long_vis;
        vx[0] = it.vertex_a_x; vy[0] = it.vertex_a_y;
        vx[1] = it.vertex_b_x; vy[1] = it.vertex_b_y;
        vx[2] = it.vertex_c_x; vy[2] = it.vertex_c_y;
        // Stable insertion sort on y, so equal y values keep their a, b, c order.
        for (int i = 1; i < 3; i++)
            for (int j = i; j > 0 && vy[j - 1] > vy[j]; j--)
            begin
                t = vy[j]; vy[j] = vy[j - 1]; vy[j - 1] = t;
                t = vx[j]; vx[j] = vx[j - 1]; vx[j - 1] = t;
            end
        r1 = round_line(vy[0]);
        r2 = round_line(vy[1]);
        r3 = round_line(vy[2]);
        top_vis  = r2 > r1;
        bot_vis  = r3 > r2;
        long_vis = r3 > r1;
        top_dx  = top_vis  ? edge_dxdy(vy[0], vy[1], vx[0], vx[1]) : 0;
        bot_dx  = bot_vis  ? edge_dxdy(vy[1], vy[2], vx[1], vx[2]) : 0;
        long_dx = long_vis ? edge_dxdy(vy[0], vy[2], vx[0], vx[2]) : 0;
        if (!top_vis)
            long_right = round_px(vx[0]) > round_px(vx[1]);
        else if (!bot_vis)
            long_right = round_px(vx[2]) > round_px(vx[1]);
        else
            long_right = top_dx < long_dx;
        long_x      = {6'b0, vx[0]};
        mid_start_x = {6'b0, vx[1]};
        row_now     = {1'b0, r1};
        row_mid     = r2;
        row_end     = r3;
        if (top_vis)
        begin
            short_x    = {6'b0, vx[0]};
            walk_phase = PH_TOP;
        end
        else if (bot_vis)
        begin
            short_x    = {6'b0, vx[1]};
            walk_phase = PH_BOTTOM;
        end
        else
        begin
            short_x    = {6'b0, vx[0]};
            walk_phase = PH_IDLE;
        end
    endtask

    task automatic advance_scanline();
        out_item_t   s;
        longint      lcol, rcol;
        logic [31:0] addr;
        if (walk_phase != PH_TOP && walk_phase != PH_BOTTOM)
            return;
        lcol = pixel_col(long_right ? short_x : long_x);
        rcol = pixel_col(long_right ? long_x : short_x);
        addr = 32'(row_now[9:0]) * 32'(width_q) + 32'(lcol);
        s.span_row     = row_now[9:0];
        s.span_x_first = lcol[9:0];
        s.span_length  = (rcol > lcol) ? 11'(rcol - lcol + 1) : 11'd1;
        s.span_address = addr[19:0];
        s.span_color   = color_q;
        s.last_span    = 1'b0;
        long_x  = long_x + long_dx;
        short_x = short_x + ((walk_phase == PH_TOP) ? top_dx : bot_dx);
        row_now = row_now + 11'd1;
        if (walk_phase == PH_TOP)
        begin
            if (row_now >= {1'b0, row_mid})
            begin
                if (row_end > row_mid)
                begin
                    walk_phase = PH_BOTTOM;
                    short_x    = mid_start_x;
                end
                else
                begin
                    walk_phase  = PH_IDLE;
                    s.last_span = 1'b1;
                end
            end
        end
        else if (row_now >= {1'b0, row_end})
        begin
            walk_phase  = PH_IDLE;
            s.last_span = 1'b1;
        end
        span_queue.push_back(s);
    endtask

    // One transfer on the input channel, then a random gap.
    task automatic send_item(in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.cmd == CMD_LOAD)
            setup_triangle(it);
        else
            advance_scanline();
        items_sent++;
        gap = quiet ? 0 : (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(0, 2));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load(logic [25:0] ax, logic [25:0] ay, logic [25:0] bx,
                        logic [25:0] by, logic [25:0] cx, logic [25:0] cy);
        in_item_t it;
        it = '{cmd: CMD_LOAD, vertex_a_x: ax, vertex_a_y: ay, vertex_b_x: bx,
               vertex_b_y: by, vertex_c_x: cx, vertex_c_y: cy};
        send_item(it);
    endtask

    task automatic step();
        in_item_t it;
        it = '{default: '0};
        it.cmd = CMD_STEP;
        // Vertex fields are don't-care on a step, so fill them with noise.
        it.vertex_a_x = 26'($urandom); it.vertex_a_y = 26'($urandom);
        it.vertex_b_x = 26'($urandom); it.vertex_b_y = 26'($urandom);
        it.vertex_c_x = 26'($urandom); it.vertex_c_y = 26'($urandom);
        send_item(it);
    endtask

    task automatic finish_triangle();
        while (walk_phase != PH_IDLE)
            step();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (span_queue.size() != 0)
            @(posedge clk);
        // Loads leave nothing to wait for, so allow the slope set-up to finish.
        repeat (SETUP_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(logic addr_index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_index == ADDR_CANVAS_WIDTH)
            width_q = value[10:0];
        else
            color_q = value[7:0];
    endtask

    function automatic logic [25:0] near_row(int row);
        longint v;
        v = (longint'(row) << FRAC) + $urandom_range(0, (1 << FRAC) - 1);
        return (v > 64'h3FFFFFF) ? 26'h3FFFFFF : v[25:0];
    endfunction

    function automatic logic [25:0] any_x();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 26'($urandom);
        if (pick == 1)
            return (pick == 1 && $urandom_range(0, 1)) ? 26'h3FFFFFF : 26'd0;
        return near_row($urandom_range(0, SIDE - 1));
    endfunction

    task automatic test_directed();
        // All-zero load gives a degenerate triangle; a step then yields nothing.
        load(26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0);
        step();
        // Maximum coordinates saturate every row at the bottom of the canvas.
        load(26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF);
        step();
        // Equal y on a and b: the flat top keeps the a, b order.
        load(26'h50000, 26'h20000, 26'h10000, 26'h20000, 26'h30000, 26'h50000);
        finish_triangle();
        // Flat bottom with the long edge on the left.
        load(26'h30000, 26'h10000, 26'h60000, 26'h40000, 26'h10000, 26'h40000);
        finish_triangle();
        // Tiny dy with a huge dx drives the slope division into saturation.
        load(26'd0, 26'h7FFF, 26'h3FFFFFF, 26'h8000, 26'd0, 26'h28000);
        finish_triangle();
        // Steep leftward edges walk the accumulators toward zero.
        load(26'h20000, 26'h100000, 26'h3FFFFFF, 26'h8000, 26'd0, 26'h110000);
        finish_triangle();
        // A new load mid-way replaces the triangle being walked.
        load(26'h100000, 26'h0, 26'h200000, 26'h100000, 26'h0, 26'h200000);
        step();
        step();
        load(26'h40000, 26'h3F00000, 26'h3FFFFFF, 26'h3FF0000, 26'h80000, 26'h3FFFFFF);
        finish_triangle();
        step();
        drain();
    endtask

    task automatic test_config();
        logic [31:0] widths[4];
        widths = '{32'd1, 32'd1024, 32'd0, 32'h7FF};
        foreach (widths[i])
        begin
            reg_write(ADDR_CANVAS_WIDTH, widths[i]);
            reg_write(ADDR_FILL_COLOR, (i % 2) ? 32'hFF : 32'h0);
            load(26'h30000, 26'h3E80000, 26'h3FFFFFF, 26'h3F00000, 26'd0, 26'h3FFFFFF);
            finish_triangle();
            drain();
        end
    endtask

    task automatic test_random();
        int base, height, pick;
        while (items_sent < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // Noise: full-range vertices, usually huge triangles.
                load(26'($urandom), 26'($urandom), 26'($urandom), 26'($urandom),
                     26'($urandom), 26'($urandom));
                repeat ($urandom_range(0, 40)) step();
                load(any_x(), near_row(0), any_x(), near_row(0), any_x(), near_row(0));
            end
            else
            begin
                base   = $urandom_range(0, SIDE - 1);
                height = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                      : $urandom_range(0, 10);
                load(any_x(), near_row(base + $urandom_range(0, height)),
                     any_x(), near_row(base + $urandom_range(0, height)),
                     any_x(), near_row(base + $urandom_range(0, height)));
                if (pick == 1)
                    repeat ($urandom_range(1, 3)) step();
                else
                begin
                    finish_triangle();
                    if ($urandom_range(0, 3) == 0)
                        step();
                end
            end
            if ($urandom_range(0, 150) == 0)
            begin
                drain();
                reg_write(ADDR_CANVAS_WIDTH, $urandom_range(0, 2047));
                reg_write(ADDR_FILL_COLOR, $urandom_range(0, 255));
            end
        end
        quiet = 1'b0;
        finish_triangle();
    endtask

    // Receiver stall pattern: mostly short bursts, now and then a long one.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 4);
            out_stall  <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
        end
        else
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
    begin
        out_item_t exp_span;
        if (rst_n && out_valid && !out_stall)
        begin
            if (span_queue.size() == 0)
            begin
                $error("span transfer with nothing expected: %p", out_data);
                fail_count++;
            end
            else
            begin
                exp_span = span_queue.pop_front();
                if (out_data.span_row !== exp_span.span_row)
                begin
                    $error("span_row expected %0d got %0d",
                           exp_span.span_row, out_data.span_row);
                    fail_count++;
                end
                if (out_data.span_x_first !== exp_span.span_x_first)
                begin
                    $error("span_x_first expected %0d got %0d",
                           exp_span.span_x_first, out_data.span_x_first);
                    fail_count++;
                end
                if (out_data.span_length !== exp_span.span_length)
                begin
                    $error("span_length expected %0d got %0d",
                           exp_span.span_length, out_data.span_length);
                    fail_count++;
                end
                if (out_data.span_address !== exp_span.span_address)
                begin
                    $error("span_address expected %0d got %0d",
                           exp_span.span_address, out_data.span_address);
                    fail_count++;
                end
                if (out_data.span_color !== exp_span.span_color)
                begin
                    $error("span_color expected %0d got %0d",
                           exp_span.span_color, out_data.span_color);
                    fail_count++;
                end
                if (out_data.last_span !== exp_span.last_span)
                begin
                    $error("last_span expected %0d got %0d",
                           exp_span.last_span, out_data.last_span);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        test_random();
        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
